FILE: rtl/core/vdh_pkg.sv
`timescale 1ns / 1ps

package vdh_pkg;

  // table geometry
  localparam int unsigned Buckets    = 1024;
  localparam int unsigned BucketW    = $clog2(Buckets);
  localparam int unsigned MaxUnique  = 4096;
  localparam int unsigned UidxW      = $clog2(MaxUnique);
  localparam int unsigned UcntW      = UidxW + 1;
  localparam int unsigned MaxInputs  = 65536;
  localparam int unsigned PosLimit   = (MaxInputs < 65536) ? MaxInputs : 65536;
  localparam int unsigned IcntW      = $clog2(PosLimit + 1);
  localparam int unsigned PosW       = 16;
  localparam int unsigned NWords     = 9;
  localparam int unsigned WidxW      = $clog2(NWords);
  localparam int unsigned RowW       = UcntW + NWords * 32;
  localparam logic [31:0] HashInit   = 32'd5381;
  localparam logic [UcntW-1:0] NilLink = UcntW'(MaxUnique);

  // configuration register indexes
  localparam logic [1:0] CfgIgnPos = 2'd0;
  localparam logic [1:0] CfgIgnTex = 2'd1;
  localparam logic [1:0] CfgIgnNrm = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic clear_head;
    logic hash_step;
    logic head_read;
    logic node_load;
    logic row_read;
    logic node_follow;
    logic finish_hit;
    logic finish_miss;
  } vdh_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic hash_done;
    logic node_ok;
    logic match;
    logic out_free;
  } vdh_status_t;

  // djb2 (xor form) over the four little-endian bytes of one word, bytes sign-extended
  function automatic logic [31:0] djb_mix(logic [31:0] h, logic [31:0] w);
    logic [31:0] acc;
    logic [31:0] b;
    acc = h;
    for (int k = 0; k < 4; k++) begin
      b   = {{24{w[8*k+7]}}, w[8*k +: 8]};
      acc = ((acc << 5) + acc) ^ b;
    end
    return acc;
  endfunction

  // float equality: both zero of any sign, or same bits and not nan
  function automatic logic float_eq(logic [31:0] a, logic [31:0] b);
    logic nan_a;
    nan_a = (a[30:0] > 31'h7F80_0000);
    return (((a | b) & 32'h7FFF_FFFF) == 32'h0) || ((a == b) && !nan_a);
  endfunction

endpackage

FILE: rtl/core/vertex_dedup_hash_indexer.sv
`timescale 1ns / 1ps

// Vertex deduplicator: each transaction carries one vertex (nine float32 bit patterns)
// and returns the index of its first equal vertex in the current mesh, or appends it
// as a new unique vertex (up to 4096). Enabled fields are hashed with djb2 into 1024
// buckets and the bucket's chain is walked in a row-wide entry memory. An item is hashed
// one word per cycle, then the bucket head memory is read, and each chain entry visited
// takes a registered entry read (StWalk) and then a compare (StCmp). After reset, and for
// any vertex with start_mesh set, a clearing pass writes all 1024 bucket heads before
// work goes on.
// A finished result sits in an output register so the next vertex can be accepted.
module vertex_dedup_hash_indexer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [0:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        start_mesh_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [31:0] tex_u_i,
  input  logic [31:0] tex_v_i,
  input  logic [31:0] tex_w_i,
  input  logic [31:0] norm_x_i,
  input  logic [31:0] norm_y_i,
  input  logic [31:0] norm_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] unique_index_o,
  output logic        is_new_o,
  output logic [15:0] source_position_o,
  output logic        store_full_o
);
  import vdh_pkg::*;

  vdh_cmd_t               cmd;
  vdh_status_t            status;
  logic [NWords-1:0][31:0] in_words;

  assign in_words = {norm_z_i, norm_y_i, norm_x_i, tex_w_i, tex_v_i, tex_u_i,
                     pos_z_i, pos_y_i, pos_x_i};

  vdh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_start_i (start_mesh_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  vdh_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_start_i        (start_mesh_i),
    .in_words_i        (in_words),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .unique_index_o    (unique_index_o),
    .is_new_o          (is_new_o),
    .source_position_o (source_position_o),
    .store_full_o      (store_full_o)
  );

endmodule

FILE: rtl/core/vdh_ctrl.sv
`timescale 1ns / 1ps

module vdh_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_start_i,
  output logic                in_ready_o,
  input  vdh_pkg::vdh_status_t status_i,
  output vdh_pkg::vdh_cmd_t   cmd_o
);
  import vdh_pkg::*;

  typedef enum logic [3:0] {
    StClear, StIdle, StHash, StHeadRd, StHeadWait, StWalk, StCmp, StDoneHit, StDoneMiss
  } state_e;

  state_e state_q, state_d;
  logic   item_q, item_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    item_d  = item_q;
    cmd_o   = '0;
    unique case (state_q)
      StClear: begin
        cmd_o.clear_head = 1'b1;
        if (status_i.clear_done) begin
          state_d = item_q ? StHash : StIdle;
          item_d  = 1'b0;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (in_start_i) begin
            state_d = StClear;
            item_d  = 1'b1;
          end else begin
            state_d = StHash;
          end
        end
      end
      StHash: begin
        cmd_o.hash_step = 1'b1;
        if (status_i.hash_done) state_d = StHeadRd;
      end
      StHeadRd: begin
        cmd_o.head_read = 1'b1;
        state_d = StHeadWait;
      end
      StHeadWait: begin
        cmd_o.node_load = 1'b1;
        state_d = StWalk;
      end
      StWalk: begin
        if (status_i.node_ok) begin
          cmd_o.row_read = 1'b1;
          state_d = StCmp;
        end else begin
          state_d = StDoneMiss;
        end
      end
      StCmp: begin
        if (status_i.match) begin
          state_d = StDoneHit;
        end else begin
          cmd_o.node_follow = 1'b1;
          state_d = StWalk;
        end
      end
      StDoneHit: begin
        if (status_i.out_free) begin
          cmd_o.finish_hit = 1'b1;
          state_d = StIdle;
        end
      end
      StDoneMiss: begin
        if (status_i.out_free) begin
          cmd_o.finish_miss = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_ready_o = (state_q == StIdle);

  // state register, clearing pass follows reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      item_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      item_q  <= item_d;
    end
  end

endmodule

FILE: rtl/core/vdh_datapath.sv
`timescale 1ns / 1ps

module vdh_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [0:0]                     cfg_wdata_i,
  input  logic                           in_start_i,
  input  logic [vdh_pkg::NWords-1:0][31:0] in_words_i,
  input  vdh_pkg::vdh_cmd_t              cmd_i,
  output vdh_pkg::vdh_status_t           status_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [vdh_pkg::UidxW-1:0]      unique_index_o,
  output logic                           is_new_o,
  output logic [vdh_pkg::PosW-1:0]       source_position_o,
  output logic                           store_full_o
);
  import vdh_pkg::*;

  logic ign_pos_q, ign_tex_q, ign_nrm_q;
  logic [NWords-1:0][31:0] words_q;
  logic [NWords-1:0]       en;
  logic [31:0]             hash_q;
  logic [WidxW-1:0]        widx_q;
  logic [BucketW-1:0]      clr_idx_q;
  logic [UcntW-1:0]        head_rdata_q;
  logic [UcntW-1:0]        node_q;
  logic [UcntW-1:0]        steps_q;
  logic [UcntW-1:0]        ucount_q;
  logic [IcntW-1:0]        icount_q;
  logic [IcntW-1:0]        cnt_eff;
  logic [PosW-1:0]         pos_q;
  logic                    sat_q;
  logic [RowW-1:0]         row_q;
  logic                    match;
  logic                    table_full;
  logic                    out_valid_q;
  logic [UidxW-1:0]        res_idx_q;
  logic                    res_new_q;
  logic [PosW-1:0]         res_pos_q;
  logic                    res_full_q;

  logic [UcntW-1:0] head_mem [Buckets];
  logic [RowW-1:0]  entry_mem [MaxUnique];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ign_pos_q <= 1'b0;
      ign_tex_q <= 1'b0;
      ign_nrm_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgIgnPos: ign_pos_q <= cfg_wdata_i[0];
        CfgIgnTex: ign_tex_q <= cfg_wdata_i[0];
        CfgIgnNrm: ign_nrm_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign en = {{3{~ign_nrm_q}}, {3{~ign_tex_q}}, {3{~ign_pos_q}}};

  // word compare against the fetched entry
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < NWords; i++) begin
      if (en[i] && !float_eq(row_q[i*32 +: 32], words_q[i])) match = 1'b0;
    end
  end

  assign table_full = (ucount_q == UcntW'(MaxUnique));
  assign cnt_eff    = in_start_i ? '0 : icount_q;

  // item payload, hash and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      words_q <= in_words_i;
      hash_q  <= HashInit;
      widx_q  <= '0;
      if (cnt_eff == IcntW'(PosLimit)) begin
        pos_q <= PosW'(PosLimit - 1);
        sat_q <= 1'b1;
      end else begin
        pos_q <= cnt_eff[PosW-1:0];
        sat_q <= 1'b0;
      end
    end
    if (cmd_i.hash_step) begin
      if (en[widx_q]) hash_q <= djb_mix(hash_q, words_q[widx_q]);
      widx_q <= widx_q + 1'b1;
    end
    if (cmd_i.node_load) begin
      node_q  <= head_rdata_q;
      steps_q <= '0;
    end
    if (cmd_i.node_follow) begin
      node_q  <= row_q[RowW-1 -: UcntW];
      steps_q <= steps_q + 1'b1;
    end
  end

  // counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ucount_q  <= '0;
      icount_q  <= '0;
      clr_idx_q <= '0;
    end else begin
      if (cmd_i.capture) begin
        if (in_start_i) ucount_q <= '0;
        if (cnt_eff != IcntW'(PosLimit)) icount_q <= cnt_eff + 1'b1;
        else icount_q <= cnt_eff;
      end
      if (cmd_i.finish_miss && !table_full) ucount_q <= ucount_q + 1'b1;
      if (cmd_i.clear_head) clr_idx_q <= clr_idx_q + 1'b1;
    end
  end

  // bucket head memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_head) begin
      head_mem[clr_idx_q] <= NilLink;
    end else if (cmd_i.finish_miss && !table_full) begin
      head_mem[hash_q[BucketW-1:0]] <= ucount_q;
    end
    if (cmd_i.head_read) head_rdata_q <= head_mem[hash_q[BucketW-1:0]];
  end

  // entry memory: link and nine words per row
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish_miss && !table_full) begin
      entry_mem[ucount_q[UidxW-1:0]] <= {head_rdata_q, words_q};
    end
    if (cmd_i.row_read) row_q <= entry_mem[node_q[UidxW-1:0]];
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish_hit || cmd_i.finish_miss) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish_hit) begin
      res_idx_q  <= node_q[UidxW-1:0];
      res_new_q  <= 1'b0;
      res_pos_q  <= pos_q;
      res_full_q <= sat_q;
    end else if (cmd_i.finish_miss) begin
      res_idx_q  <= table_full ? '0 : ucount_q[UidxW-1:0];
      res_new_q  <= !table_full;
      res_pos_q  <= pos_q;
      res_full_q <= sat_q | table_full;
    end
  end

  assign status_o.clear_done = (clr_idx_q == BucketW'(Buckets - 1));
  assign status_o.hash_done  = (widx_q == WidxW'(NWords - 1));
  assign status_o.node_ok    = (node_q < ucount_q) && (steps_q < ucount_q);
  assign status_o.match      = match;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign unique_index_o    = res_idx_q;
  assign is_new_o          = res_new_q;
  assign source_position_o = res_pos_q;
  assign store_full_o      = res_full_q;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import vdh_pkg::*;

  localparam int unsigned PredBuckets = 1024;
  localparam int unsigned PredMaxUniq = 4096;
  localparam int unsigned PredLimit   = 65536;
  localparam int unsigned NilIdx      = 4096;
  localparam longint      CycleLimit  = 2000000;

  typedef struct packed {
    logic        start_mesh;
    logic [31:0] pos_x, pos_y, pos_z, tex_u, tex_v, tex_w, norm_x, norm_y, norm_z;
  } vertex_t;

  typedef struct packed {
    logic [11:0] unique_index;
    logic        is_new;
    logic [15:0] source_position;
    logic        store_full;
  } dedup_res_t;

  typedef struct {
    vertex_t    vtx;
    logic       has_exp;
    dedup_res_t exp;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [0:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  vertex_t     vtx_drv = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [11:0] unique_index_o;
  logic        is_new_o;
  logic [15:0] source_position_o;
  logic        store_full_o;

  vertex_dedup_hash_indexer dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o,
    .start_mesh_i(vtx_drv.start_mesh),
    .pos_x_i(vtx_drv.pos_x), .pos_y_i(vtx_drv.pos_y), .pos_z_i(vtx_drv.pos_z),
    .tex_u_i(vtx_drv.tex_u), .tex_v_i(vtx_drv.tex_v), .tex_w_i(vtx_drv.tex_w),
    .norm_x_i(vtx_drv.norm_x), .norm_y_i(vtx_drv.norm_y), .norm_z_i(vtx_drv.norm_z),
    .out_valid_o, .out_ready_i, .unique_index_o, .is_new_o,
    .source_position_o, .store_full_o
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  int unsigned head_tbl [PredBuckets];
  int unsigned link_tbl [PredMaxUniq];
  logic [31:0] word_tbl [PredMaxUniq][9];
  int unsigned uniq_cnt, in_cnt;
  logic [2:0]  ign_grp;

  dedup_res_t  expected_q[$];
  int          n_errors;
  longint      cycle_cnt;
  bit          idle_off;
  int          hold_cycles;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    n_errors++;
  endtask

  function automatic logic [31:0] hash_word(logic [31:0] h, logic [31:0] w);
    logic [31:0] b;
    for (int k = 0; k < 4; k++) begin
      b = {{24{w[8*k+7]}}, w[8*k +: 8]};
      h = (h * 33) ^ b;
    end
    return h;
  endfunction

  function automatic bit words_equal(logic [31:0] a, logic [31:0] b);
    if (a[30:0] == 0 && b[30:0] == 0) return 1;
    return a == b && !(a[30:0] > 31'h7F80_0000);
  endfunction

  // dedup prediction for one vertex
  function automatic dedup_res_t dedup_predict(vertex_t v);
    dedup_res_t  r;
    logic [31:0] w[9];
    logic [31:0] h;
    int unsigned bkt, node, steps;
    bit          found, same;
    w = '{v.pos_x, v.pos_y, v.pos_z, v.tex_u, v.tex_v, v.tex_w,
          v.norm_x, v.norm_y, v.norm_z};
    r = '0;
    if (v.start_mesh) begin
      foreach (head_tbl[b]) head_tbl[b] = NilIdx;
      uniq_cnt = 0;
      in_cnt = 0;
    end
    if (in_cnt >= PredLimit) begin
      r.store_full = 1;
      r.source_position = 16'(PredLimit - 1);
    end else begin
      r.source_position = 16'(in_cnt);
      in_cnt++;
    end
    h = 32'd5381;
    for (int i = 0; i < 9; i++) if (!ign_grp[i/3]) h = hash_word(h, w[i]);
    bkt = h % PredBuckets;
    node = head_tbl[bkt];
    steps = 0;
    found = 0;
    while (!found && node < uniq_cnt && node < NilIdx && steps < uniq_cnt) begin
      same = 1;
      for (int i = 0; i < 9; i++)
        if (!ign_grp[i/3] && !words_equal(word_tbl[node][i], w[i])) same = 0;
      if (same) begin
        found = 1;
        r.unique_index = 12'(node);
      end else begin
        node = link_tbl[node];
      end
      steps++;
    end
    if (!found) begin
      if (uniq_cnt >= PredMaxUniq) begin
        r.store_full = 1;
        r.unique_index = '0;
      end else begin
        for (int i = 0; i < 9; i++) word_tbl[uniq_cnt][i] = w[i];
        link_tbl[uniq_cnt] = head_tbl[bkt];
        head_tbl[bkt] = uniq_cnt;
        r.unique_index = 12'(uniq_cnt);
        r.is_new = 1;
        uniq_cnt++;
      end
    end
    return r;
  endfunction

  task automatic write_cfg(input logic [1:0] idx, input logic val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ign_grp[idx] = val;
  endtask

  task automatic set_ignores(input logic [2:0] m);
    write_cfg(CfgIgnPos, m[0]);
    write_cfg(CfgIgnTex, m[1]);
    write_cfg(CfgIgnNrm, m[2]);
  endtask

  // send one vertex; expectation pushed when accepted
  task automatic send_vertex(input vertex_t v, input bit has_exp, input dedup_res_t exp);
    dedup_res_t p;
    while (!idle_off && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    vtx_drv <= v;
    do @(posedge clk_i); while (!in_ready_o);
    p = dedup_predict(v);
    if (has_exp && p !== exp) report_mismatch("directed row", p, exp);
    expected_q.push_back(p);
  endtask

  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_float();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7FC0_0000 | $urandom_range(255);
      3: return 32'h7F80_0000;
      4: return (32'($urandom_range(7)) << 20) | 32'h3F80_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic vertex_t rand_vertex(bit st);
    vertex_t v;
    v.start_mesh = st;
    v.pos_x = rand_float(); v.pos_y = rand_float(); v.pos_z = rand_float();
    v.tex_u = rand_float(); v.tex_v = rand_float(); v.tex_w = rand_float();
    v.norm_x = rand_float(); v.norm_y = rand_float(); v.norm_z = rand_float();
    return v;
  endfunction

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    dedup_res_t got, want;
    cycle_cnt <= cycle_cnt + 1;
    if (out_valid_o && out_ready_i) begin
      got = '{unique_index_o, is_new_o, source_position_o, store_full_o};
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", got, 0);
      end else begin
        want = expected_q.pop_front();
        if (got.unique_index !== want.unique_index)
          report_mismatch("unique_index", got.unique_index, want.unique_index);
        if (got.is_new !== want.is_new) report_mismatch("is_new", got.is_new, want.is_new);
        if (got.source_position !== want.source_position)
          report_mismatch("source_position", got.source_position, want.source_position);
        if (got.store_full !== want.store_full)
          report_mismatch("store_full", got.store_full, want.store_full);
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= idle_off || ($urandom_range(99) >= 7);
    end
  end

  // timeout
  always @(posedge clk_i) begin
    if (cycle_cnt > CycleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    stim_row_t  rows[$];
    stim_row_t  row;
    vertex_t    v;
    vertex_t    pool[$];
    logic [2:0] modes[6];
    modes = '{3'b000, 3'b111, 3'b001, 3'b010, 3'b100, 3'b110};
    n_errors = 0;
    cycle_cnt = 0;
    idle_off = 0;
    hold_cycles = 0;
    ign_grp = '0;
    foreach (head_tbl[b]) head_tbl[b] = NilIdx;
    uniq_cnt = 0;
    in_cnt = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    v = '0; v.start_mesh = 1;
    rows.push_back('{v, 1, '{12'd0, 1'b1, 16'd0, 1'b0}});
    v.start_mesh = 0;
    rows.push_back('{v, 1, '{12'd0, 1'b0, 16'd1, 1'b0}});
    v = '1; v.start_mesh = 0;
    rows.push_back('{v, 1, '{12'd1, 1'b1, 16'd2, 1'b0}});
    rows.push_back('{v, 1, '{12'd2, 1'b1, 16'd3, 1'b0}});
    v = '0; v.pos_x = 32'h8000_0000;
    rows.push_back('{v, 0, '0});
    v = '0; v.pos_x = 32'h7F80_0000; v.norm_z = 32'h8080_8080;
    rows.push_back('{v, 0, '0});
    rows.push_back('{v, 0, '0});
    v.pos_y = 32'h7F80_0001;
    rows.push_back('{v, 0, '0});
    v = '0; v.start_mesh = 1; v.tex_w = 32'h3F80_0000;
    rows.push_back('{v, 1, '{12'd0, 1'b1, 16'd0, 1'b0}});
    v.start_mesh = 0;
    rows.push_back('{v, 1, '{12'd0, 1'b0, 16'd1, 1'b0}});
    foreach (rows[i]) send_vertex(rows[i].vtx, rows[i].has_exp, rows[i].exp);
    drain_and_settle();

    // all fields ignored: everything matches the first vertex
    set_ignores(3'b111);
    send_vertex(rand_vertex(1), 1, '{12'd0, 1'b1, 16'd0, 1'b0});
    for (int i = 0; i < 4; i++)
      send_vertex(rand_vertex(0), 1, '{12'd0, 1'b0, 16'(i + 1), 1'b0});
    drain_and_settle();

    // random phases over ignore settings, repeats drawn from a pool
    for (int ph = 0; ph < 6; ph++) begin
      set_ignores(modes[ph]);
      pool.delete();
      idle_off = (ph == 2);
      if (ph == 3) hold_cycles = 400;
      for (int i = 0; i < 65; i++) begin
        if (pool.size() != 0 && $urandom_range(99) < 45) begin
          v = pool[$urandom_range(pool.size() - 1)];
          if ($urandom_range(3) == 0) v.norm_y = rand_float();
          v.start_mesh = 0;
        end else begin
          v = rand_vertex(i == 0 || $urandom_range(99) == 0);
          pool.push_back(v);
        end
        send_vertex(v, 0, '0);
      end
      drain_and_settle();
    end
    idle_off = 0;

    if (n_errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/vdh_pkg.sv
rtl/core/vdh_ctrl.sv
rtl/core/vdh_datapath.sv
rtl/core/vertex_dedup_hash_indexer.sv
tb/sv/tb_top.sv
